[design/rcls_pkg.sv]
// Package for the radio-control link supervisor and slew limiter.
// Holds the item, result, state and configuration types and the small helper functions.
// Has no dependencies; the core and the top level import it.
package rcls_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_GAP  = 3'd0;
    localparam logic [2:0] REG_SOFT_GAP   = 3'd1;
    localparam logic [2:0] REG_HARD_GAP   = 3'd2;
    localparam logic [2:0] REG_FREEZE_GAP = 3'd3;
    localparam logic [2:0] REG_MISS_LIMIT = 3'd4;
    localparam logic [2:0] REG_STEP_LIMIT = 3'd5;
    localparam logic [2:0] REG_CHAN_MIN   = 3'd6;
    localparam logic [2:0] REG_CHAN_MAX   = 3'd7;

    // Item kinds.
    localparam logic KIND_LINK = 1'b0;
    localparam logic KIND_CHAN = 1'b1;

    // Fault codes.
    localparam logic FAULT_TIMEOUT   = 1'b0;
    localparam logic FAULT_HARD_LOST = 1'b1;

    // Reset values.
    localparam logic [15:0] RST_FRAME_GAP  = 16'd60;
    localparam logic [15:0] RST_SOFT_GAP   = 16'd120;
    localparam logic [15:0] RST_HARD_GAP   = 16'd500;
    localparam logic [15:0] RST_FREEZE_GAP = 16'd150;
    localparam logic [7:0]  RST_MISS_LIMIT = 8'd3;
    localparam logic [11:0] RST_STEP_LIMIT = 12'd120;
    localparam logic [15:0] RST_CHAN_MIN   = 16'd900;
    localparam logic [15:0] RST_CHAN_MAX   = 16'd2100;
    localparam logic [15:0] RST_CENTER     = 16'd1500;
    localparam logic [7:0]  MISS_SAT       = 8'd255;

    typedef struct packed {
        logic [15:0] frame_gap;
        logic [15:0] soft_gap;
        logic [15:0] hard_gap;
        logic [15:0] freeze_gap;
        logic [7:0]  miss_limit;
        logic [11:0] step_limit;
        logic [15:0] chan_min;
        logic [15:0] chan_max;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        bytes_seen;
        logic [15:0] throttle;
        logic [15:0] steer;
        logic [15:0] engine;
        logic [15:0] ignition;
        logic [15:0] starter;
    } t_item;

    typedef struct packed {
        logic [31:0] last_byte_time;
        logic [31:0] last_frame_time;
        logic        frame_seen_once;
        logic [7:0]  frame_miss_count;
        logic [7:0]  byte_miss_count;
        logic        soft_lost;
        logic        confirm;
        logic [15:0] prev_throttle;
        logic [15:0] prev_steer;
    } t_state;

    typedef struct packed {
        logic        fault_raised;
        logic        fault_code;
        logic        link_lost;
        logic        confirm_needed;
        logic        alive_pulse;
        logic        channels_updated;
        logic [15:0] throttle;
        logic [15:0] steer;
        logic [15:0] engine;
        logic [15:0] ignition;
        logic [15:0] starter;
    } t_result;

    // True when a channel value lies in the valid pulse window.
    function automatic logic in_range(input logic [15:0] v, input logic [15:0] lo,
                                      input logic [15:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Miss counter increment that sticks at its top value.
    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == MISS_SAT) ? c : c + 8'd1;
    endfunction

    // Move prev toward target by at most step.
    function automatic logic [15:0] slew(input logic [15:0] prev, input logic [15:0] target,
                                         input logic [11:0] step);
        logic signed [17:0] d;
        logic signed [17:0] m;
        logic signed [17:0] sum;
        d = $signed({2'b00, target}) - $signed({2'b00, prev});
        m = $signed({6'b00_0000, step});
        if (d > m) begin
            d = m;
        end else if (d < -m) begin
            d = -m;
        end
        sum = $signed({2'b00, prev}) + d;
        return sum[15:0];
    endfunction

endpackage

[design/rc_link_supervisor_slew_limiter.sv]
// Radio-control link supervisor with throttle and steer slew limiting.
// A request enters the input register; its result then goes to the result register.
// Throughput: one request per cycle unless the result side stalls; the input register and
// the result register form a two-stage pipeline, and the state updates as a request leaves
// the input register. Reset (synchronous, active low) restores register defaults, clears the
// link state and centers throttle and steer at 1500. Depends on rcls_pkg and rcls_core.
module rc_link_supervisor_slew_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_now_ms,
    input  logic        i_bytes_seen,
    input  logic [15:0] i_throttle_in,
    input  logic [15:0] i_steer_in,
    input  logic [15:0] i_engine_in,
    input  logic [15:0] i_ignition_in,
    input  logic [15:0] i_starter_in,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_fault_raised,
    output logic        o_fault_code,
    output logic        o_link_lost,
    output logic        o_confirm_needed,
    output logic        o_alive_pulse,
    output logic        o_channels_updated,
    output logic [15:0] o_throttle_out,
    output logic [15:0] o_steer_out,
    output logic [15:0] o_engine_out,
    output logic [15:0] o_ignition_out,
    output logic [15:0] o_starter_out
);
    import rcls_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    logic    r_item_valid;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    w_adv;

    // A request moves on when the result register is free or being drained.
    assign w_adv      = r_item_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_item_valid && r_out_valid && i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_gap  <= RST_FRAME_GAP;
            r_cfg.soft_gap   <= RST_SOFT_GAP;
            r_cfg.hard_gap   <= RST_HARD_GAP;
            r_cfg.freeze_gap <= RST_FREEZE_GAP;
            r_cfg.miss_limit <= RST_MISS_LIMIT;
            r_cfg.step_limit <= RST_STEP_LIMIT;
            r_cfg.chan_min   <= RST_CHAN_MIN;
            r_cfg.chan_max   <= RST_CHAN_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_GAP:  r_cfg.frame_gap  <= i_cfg_data;
                REG_SOFT_GAP:   r_cfg.soft_gap   <= i_cfg_data;
                REG_HARD_GAP:   r_cfg.hard_gap   <= i_cfg_data;
                REG_FREEZE_GAP: r_cfg.freeze_gap <= i_cfg_data;
                REG_MISS_LIMIT: r_cfg.miss_limit <= i_cfg_data[7:0];
                REG_STEP_LIMIT: r_cfg.step_limit <= i_cfg_data[11:0];
                REG_CHAN_MIN:   r_cfg.chan_min   <= i_cfg_data;
                REG_CHAN_MAX:   r_cfg.chan_max   <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item.kind       <= i_kind;
            r_item.now_ms     <= i_now_ms;
            r_item.bytes_seen <= i_bytes_seen;
            r_item.throttle   <= i_throttle_in;
            r_item.steer      <= i_steer_in;
            r_item.engine     <= i_engine_in;
            r_item.ignition   <= i_ignition_in;
            r_item.starter    <= i_starter_in;
        end
    end

    // Evaluation of the held request.
    rcls_core u_core (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Supervisor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_byte_time   <= 32'd0;
            r_state.last_frame_time  <= 32'd0;
            r_state.frame_seen_once  <= 1'b0;
            r_state.frame_miss_count <= 8'd0;
            r_state.byte_miss_count  <= 8'd0;
            r_state.soft_lost        <= 1'b0;
            r_state.confirm          <= 1'b0;
            r_state.prev_throttle    <= RST_CENTER;
            r_state.prev_steer       <= RST_CENTER;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_fault_raised     = r_result.fault_raised;
    assign o_fault_code       = r_result.fault_code;
    assign o_link_lost        = r_result.link_lost;
    assign o_confirm_needed   = r_result.confirm_needed;
    assign o_alive_pulse      = r_result.alive_pulse;
    assign o_channels_updated = r_result.channels_updated;
    assign o_throttle_out     = r_result.throttle;
    assign o_steer_out        = r_result.steer;
    assign o_engine_out       = r_result.engine;
    assign o_ignition_out     = r_result.ignition;
    assign o_starter_out      = r_result.starter;

endmodule

[design/rcls_core.sv]
// Combinational evaluation of one request against the supervisor state.
// Produces the next state and the result item; depends on rcls_pkg.
module rcls_core (
    input  rcls_pkg::t_cfg    i_cfg,
    input  rcls_pkg::t_item   i_item,
    input  rcls_pkg::t_state  i_state,
    output rcls_pkg::t_state  o_state,
    output rcls_pkg::t_result o_result
);
    import rcls_pkg::*;

    logic        w_thr_ok, w_str_ok, w_eng_ok, w_ign_ok, w_sta_ok;
    logic        w_frame_ok;
    logic [31:0] w_lbt, w_lft;
    logic        w_seen;
    logic [31:0] w_frame_age, w_byte_gap, w_chan_age;
    logic        w_frame_late;
    logic [7:0]  w_fmc;

    // Range checks on every channel.
    assign w_thr_ok = in_range(i_item.throttle, i_cfg.chan_min, i_cfg.chan_max);
    assign w_str_ok = in_range(i_item.steer, i_cfg.chan_min, i_cfg.chan_max);
    assign w_eng_ok = in_range(i_item.engine, i_cfg.chan_min, i_cfg.chan_max);
    assign w_ign_ok = in_range(i_item.ignition, i_cfg.chan_min, i_cfg.chan_max);
    assign w_sta_ok = in_range(i_item.starter, i_cfg.chan_min, i_cfg.chan_max);

    // Link timestamps as updated by this request.
    assign w_frame_ok  = i_item.bytes_seen && w_thr_ok && w_str_ok;
    assign w_lbt       = i_item.bytes_seen ? i_item.now_ms : i_state.last_byte_time;
    assign w_lft       = w_frame_ok ? i_item.now_ms : i_state.last_frame_time;
    assign w_seen      = i_state.frame_seen_once || w_frame_ok;
    assign w_frame_age = i_item.now_ms - w_lft;
    assign w_byte_gap  = i_item.now_ms - w_lbt;
    assign w_chan_age  = i_item.now_ms - i_state.last_frame_time;

    // Frame miss counter.
    assign w_frame_late = w_seen && (w_frame_age > {16'd0, i_cfg.frame_gap});
    assign w_fmc        = w_frame_late ? sat_inc(i_state.frame_miss_count) : 8'd0;

    // Next state and result.
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.kind == KIND_LINK) begin
            o_state.last_byte_time   = w_lbt;
            o_state.last_frame_time  = w_lft;
            o_state.frame_seen_once  = w_seen;
            o_state.frame_miss_count = w_fmc;
            if (w_frame_late && (w_fmc >= i_cfg.miss_limit)) begin
                // Frame timeout ends the update.
                o_result.fault_raised = 1'b1;
                o_result.fault_code   = FAULT_TIMEOUT;
            end else begin
                if (w_byte_gap > {16'd0, i_cfg.soft_gap}) begin
                    o_state.byte_miss_count = sat_inc(i_state.byte_miss_count);
                    if (sat_inc(i_state.byte_miss_count) >= i_cfg.miss_limit) begin
                        o_state.soft_lost = 1'b1;
                        o_state.confirm   = 1'b1;
                    end
                end else begin
                    o_state.byte_miss_count = 8'd0;
                end
                if (w_byte_gap > {16'd0, i_cfg.hard_gap}) begin
                    o_result.fault_raised = 1'b1;
                    o_result.fault_code   = FAULT_HARD_LOST;
                end else if (w_frame_ok) begin
                    o_state.soft_lost    = 1'b0;
                    o_result.alive_pulse = 1'b1;
                end
            end
        end else if (!i_state.soft_lost) begin
            if (w_chan_age > {16'd0, i_cfg.freeze_gap}) begin
                // Frozen channels.
                o_result.fault_raised = 1'b1;
                o_result.fault_code   = FAULT_TIMEOUT;
            end else if (!(w_thr_ok && w_str_ok && w_eng_ok && w_ign_ok && w_sta_ok)) begin
                o_result.fault_raised = 1'b1;
                o_result.fault_code   = FAULT_TIMEOUT;
            end else begin
                o_state.prev_throttle = slew(i_state.prev_throttle, i_item.throttle,
                                             i_cfg.step_limit);
                o_state.prev_steer    = slew(i_state.prev_steer, i_item.steer,
                                             i_cfg.step_limit);
                o_result.channels_updated = 1'b1;
                o_result.throttle = o_state.prev_throttle;
                o_result.steer    = o_state.prev_steer;
                o_result.engine   = i_item.engine;
                o_result.ignition = i_item.ignition;
                o_result.starter  = i_item.starter;
            end
        end
        o_result.link_lost      = o_state.soft_lost;
        o_result.confirm_needed = o_state.confirm;
    end

endmodule

[tb/rcls_link_checker.sv]
// Checker for the radio-control link supervisor and slew limiter.
// Watches the configuration port and the request and result channels, predicts each result
// and compares it field by field. Depends on rcls_pkg.
module rcls_link_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_now_ms,
    input  logic        i_bytes_seen,
    input  logic [15:0] i_throttle_in,
    input  logic [15:0] i_steer_in,
    input  logic [15:0] i_engine_in,
    input  logic [15:0] i_ignition_in,
    input  logic [15:0] i_starter_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_fault_raised,
    input  logic        i_fault_code,
    input  logic        i_link_lost,
    input  logic        i_confirm_needed,
    input  logic        i_alive_pulse,
    input  logic        i_channels_updated,
    input  logic [15:0] i_throttle_out,
    input  logic [15:0] i_steer_out,
    input  logic [15:0] i_engine_out,
    input  logic [15:0] i_ignition_out,
    input  logic [15:0] i_starter_out,
    output int          o_fail_count,
    output int          o_pending
);
    import rcls_pkg::*;

    t_cfg    regs;
    t_state  link_st;
    t_result supervisor_results[$];
    int      fail_n = 0;

    // Register defaults and link state as they stand after reset.
    task automatic restore_defaults();
        regs.frame_gap  = RST_FRAME_GAP;
        regs.soft_gap   = RST_SOFT_GAP;
        regs.hard_gap   = RST_HARD_GAP;
        regs.freeze_gap = RST_FREEZE_GAP;
        regs.miss_limit = RST_MISS_LIMIT;
        regs.step_limit = RST_STEP_LIMIT;
        regs.chan_min   = RST_CHAN_MIN;
        regs.chan_max   = RST_CHAN_MAX;
        link_st = '0;
        link_st.prev_throttle = RST_CENTER;
        link_st.prev_steer    = RST_CENTER;
    endtask

    function automatic logic in_window(input logic [15:0] v);
        return (v >= regs.chan_min) && (v <= regs.chan_max);
    endfunction

    // Miss counters stop at 255.
    function automatic logic [7:0] bump_miss(input logic [7:0] c);
        return (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

    // Move from the held value toward the request by at most step_limit.
    function automatic logic [15:0] step_toward(input logic [15:0] held,
                                                input logic [15:0] target);
        int diff;
        int lim;
        diff = int'(target) - int'(held);
        lim = int'(regs.step_limit);
        if (diff > lim) begin
            diff = lim;
        end else if (diff < -lim) begin
            diff = -lim;
        end
        return 16'(int'(held) + diff);
    endfunction

    // Expected result of one request; updates the predicted link state.
    function automatic t_result predict_update(input t_item it);
        t_result     r;
        logic        good_frame;
        logic        timed_out;
        logic [31:0] frame_age;
        logic [31:0] byte_gap;
        r = '0;
        if (it.kind == KIND_LINK) begin
            good_frame = it.bytes_seen && in_window(it.throttle) && in_window(it.steer);
            timed_out = 1'b0;
            if (it.bytes_seen) begin
                link_st.last_byte_time = it.now_ms;
            end
            if (good_frame) begin
                link_st.last_frame_time = it.now_ms;
                link_st.frame_seen_once = 1'b1;
            end
            frame_age = it.now_ms - link_st.last_frame_time;
            if (link_st.frame_seen_once && frame_age > {16'd0, regs.frame_gap}) begin
                link_st.frame_miss_count = bump_miss(link_st.frame_miss_count);
                if (link_st.frame_miss_count >= regs.miss_limit) begin
                    r.fault_raised = 1'b1;
                    r.fault_code = FAULT_TIMEOUT;
                    timed_out = 1'b1;
                end
            end else begin
                link_st.frame_miss_count = 8'd0;
            end
            // Byte-gap checks run only when the frame timeout did not fire.
            if (!timed_out) begin
                byte_gap = it.now_ms - link_st.last_byte_time;
                if (byte_gap > {16'd0, regs.soft_gap}) begin
                    link_st.byte_miss_count = bump_miss(link_st.byte_miss_count);
                    if (link_st.byte_miss_count >= regs.miss_limit) begin
                        link_st.soft_lost = 1'b1;
                        link_st.confirm = 1'b1;
                    end
                end else begin
                    link_st.byte_miss_count = 8'd0;
                end
                if (byte_gap > {16'd0, regs.hard_gap}) begin
                    r.fault_raised = 1'b1;
                    r.fault_code = FAULT_HARD_LOST;
                end else if (good_frame) begin
                    link_st.soft_lost = 1'b0;
                    r.alive_pulse = 1'b1;
                end
            end
        end else if (!link_st.soft_lost) begin
            frame_age = it.now_ms - link_st.last_frame_time;
            if (frame_age > {16'd0, regs.freeze_gap}) begin
                r.fault_raised = 1'b1;
            end else if (!(in_window(it.throttle) && in_window(it.steer) &&
                           in_window(it.engine) && in_window(it.ignition) &&
                           in_window(it.starter))) begin
                r.fault_raised = 1'b1;
            end else begin
                link_st.prev_throttle = step_toward(link_st.prev_throttle, it.throttle);
                link_st.prev_steer = step_toward(link_st.prev_steer, it.steer);
                r.throttle = link_st.prev_throttle;
                r.steer = link_st.prev_steer;
                r.engine = it.engine;
                r.ignition = it.ignition;
                r.starter = it.starter;
                r.channels_updated = 1'b1;
            end
        end
        r.link_lost = link_st.soft_lost;
        r.confirm_needed = link_st.confirm;
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_n++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_flag(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_error($sformatf("%s is %0b, expected %0b", name, got, want));
        end
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        check_flag("fault_raised", got.fault_raised, want.fault_raised);
        check_flag("fault_code", got.fault_code, want.fault_code);
        check_flag("link_lost", got.link_lost, want.link_lost);
        check_flag("confirm_needed", got.confirm_needed, want.confirm_needed);
        check_flag("alive_pulse", got.alive_pulse, want.alive_pulse);
        check_flag("channels_updated", got.channels_updated, want.channels_updated);
        check_field("throttle_out", got.throttle, want.throttle);
        check_field("steer_out", got.steer, want.steer);
        check_field("engine_out", got.engine, want.engine);
        check_field("ignition_out", got.ignition, want.ignition);
        check_field("starter_out", got.starter, want.starter);
    endtask

    // Everything is sampled at the rising edge, before the block's outputs move.
    always @(posedge i_clk) begin : l_watch
        t_result got;
        t_item   req;
        if (!i_rst_n) begin
            restore_defaults();
            supervisor_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_GAP:  regs.frame_gap  = i_cfg_data;
                    REG_SOFT_GAP:   regs.soft_gap   = i_cfg_data;
                    REG_HARD_GAP:   regs.hard_gap   = i_cfg_data;
                    REG_FREEZE_GAP: regs.freeze_gap = i_cfg_data;
                    REG_MISS_LIMIT: regs.miss_limit = i_cfg_data[7:0];
                    REG_STEP_LIMIT: regs.step_limit = i_cfg_data[11:0];
                    REG_CHAN_MIN:   regs.chan_min   = i_cfg_data;
                    REG_CHAN_MAX:   regs.chan_max   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_fault_raised, i_fault_code, i_link_lost, i_confirm_needed,
                       i_alive_pulse, i_channels_updated, i_throttle_out, i_steer_out,
                       i_engine_out, i_ignition_out, i_starter_out};
                if (supervisor_results.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    compare_result(got, supervisor_results.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall) begin
                req = {i_kind, i_now_ms, i_bytes_seen, i_throttle_in, i_steer_in,
                       i_engine_in, i_ignition_in, i_starter_in};
                supervisor_results.push_back(predict_update(req));
            end
        end
        o_pending <= supervisor_results.size();
        o_fail_count <= fail_n;
    end

endmodule

[tb/tb.sv]
// Top of the testbench for the radio-control link supervisor and slew limiter.
// Generates directed and random requests, configuration phases and output stalls;
// depends on rcls_pkg, the block and rcls_link_checker.
module tb;
    import rcls_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [31:0] i_now_ms;
    logic        i_bytes_seen;
    logic [15:0] i_throttle_in;
    logic [15:0] i_steer_in;
    logic [15:0] i_engine_in;
    logic [15:0] i_ignition_in;
    logic [15:0] i_starter_in;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_fault_raised;
    logic        o_fault_code;
    logic        o_link_lost;
    logic        o_confirm_needed;
    logic        o_alive_pulse;
    logic        o_channels_updated;
    logic [15:0] o_throttle_out;
    logic [15:0] o_steer_out;
    logic [15:0] o_engine_out;
    logic [15:0] o_ignition_out;
    logic [15:0] o_starter_out;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          stall_hold = 0;
    bit          calm = 1'b0;
    t_cfg        cur_cfg;
    logic [31:0] clock_ms;

    rc_link_supervisor_slew_limiter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_now_ms(i_now_ms), .i_bytes_seen(i_bytes_seen),
        .i_throttle_in(i_throttle_in), .i_steer_in(i_steer_in),
        .i_engine_in(i_engine_in), .i_ignition_in(i_ignition_in),
        .i_starter_in(i_starter_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_fault_raised(o_fault_raised), .o_fault_code(o_fault_code),
        .o_link_lost(o_link_lost), .o_confirm_needed(o_confirm_needed),
        .o_alive_pulse(o_alive_pulse), .o_channels_updated(o_channels_updated),
        .o_throttle_out(o_throttle_out), .o_steer_out(o_steer_out),
        .o_engine_out(o_engine_out), .o_ignition_out(o_ignition_out),
        .o_starter_out(o_starter_out)
    );

    rcls_link_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_kind(i_kind), .i_now_ms(i_now_ms), .i_bytes_seen(i_bytes_seen),
        .i_throttle_in(i_throttle_in), .i_steer_in(i_steer_in),
        .i_engine_in(i_engine_in), .i_ignition_in(i_ignition_in),
        .i_starter_in(i_starter_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_fault_raised(o_fault_raised), .i_fault_code(o_fault_code),
        .i_link_lost(o_link_lost), .i_confirm_needed(o_confirm_needed),
        .i_alive_pulse(o_alive_pulse), .i_channels_updated(o_channels_updated),
        .i_throttle_out(o_throttle_out), .i_steer_out(o_steer_out),
        .i_engine_out(o_engine_out), .i_ignition_out(o_ignition_out),
        .i_starter_out(o_starter_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Result-side back-pressure.
    always @(posedge i_clk) begin
        if (calm || stall_hold == 0) begin
            stall_hold = calm ? 0 : idle_len();
        end else begin
            stall_hold = stall_hold - 1;
        end
        i_out_stall <= (stall_hold != 0);
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_item make_req(input logic kind, input logic [31:0] now,
                                       input logic bytes, input logic [15:0] thr,
                                       input logic [15:0] str, input logic [15:0] eng,
                                       input logic [15:0] ign, input logic [15:0] sta);
        return {kind, now, bytes, thr, str, eng, ign, sta};
    endfunction

    // Channel value: mostly inside the window, some at its borders, some anywhere.
    function automatic logic [15:0] chan_val();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88 && cur_cfg.chan_min <= cur_cfg.chan_max) begin
            return 16'($urandom_range(cur_cfg.chan_max, cur_cfg.chan_min));
        end else if (r < 95) begin
            case ($urandom_range(0, 3))
                0: return cur_cfg.chan_min;
                1: return cur_cfg.chan_max;
                2: return cur_cfg.chan_min - 16'd1;
                default: return cur_cfg.chan_max + 16'd1;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Random request: mostly a plausible timeline scaled to the gap settings,
    // with a share of pure noise.
    function automatic t_item rand_req();
        t_item it;
        int    r;
        int    delta;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            it = 114'({$urandom, $urandom, $urandom, $urandom});
            return it;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            delta = $urandom_range(0, int'(cur_cfg.frame_gap) + 1);
        end else if (r < 80) begin
            delta = $urandom_range(0, int'(cur_cfg.freeze_gap) + int'(cur_cfg.soft_gap) + 2);
        end else if (r < 95) begin
            delta = $urandom_range(0, 2 * int'(cur_cfg.hard_gap) + 2);
        end else begin
            delta = $urandom_range(0, 300000);
        end
        clock_ms = clock_ms + 32'(delta);
        it.kind = 1'($urandom_range(0, 1));
        it.now_ms = clock_ms;
        it.bytes_seen = ($urandom_range(0, 99) < 85);
        it.throttle = chan_val();
        it.steer = chan_val();
        it.engine = chan_val();
        it.ignition = chan_val();
        it.starter = chan_val();
        return it;
    endfunction

    // Register set for each phase; some phases pin the extremes.
    function automatic t_cfg phase_cfg(input int phase);
        t_cfg c;
        c.frame_gap  = 16'($urandom_range(20, 200));
        c.soft_gap   = 16'($urandom_range(40, 300));
        c.hard_gap   = 16'($urandom_range(150, 1000));
        c.freeze_gap = 16'($urandom_range(40, 300));
        c.miss_limit = 8'($urandom_range(1, 5));
        c.step_limit = 12'($urandom_range(0, 400));
        c.chan_min   = 16'($urandom_range(700, 1100));
        c.chan_max   = 16'($urandom_range(1800, 2300));
        case (phase)
            2: begin
                c = {16'd1, 16'd1, 16'd1, 16'd1, 8'd1, 12'd0, 16'd0, 16'hFFFF};
            end
            4: begin
                c = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF,
                     16'd0, 16'hFFFF};
            end
            6: begin
                // A zero miss limit fires on every miss; the window is empty.
                c.miss_limit = 8'd0;
                c.chan_min = 16'd2000;
                c.chan_max = 16'd1000;
            end
            8: begin
                c.miss_limit = 8'd1;
                c.step_limit = 12'hFFF;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Drives one request and holds it until the block takes it.
    task automatic send_req(input t_item it);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= it.kind;
        i_now_ms      <= it.now_ms;
        i_bytes_seen  <= it.bytes_seen;
        i_throttle_in <= it.throttle;
        i_steer_in    <= it.steer;
        i_engine_in   <= it.engine;
        i_ignition_in <= it.ignition;
        i_starter_in  <= it.starter;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Waits until every expected result has come back.
    task automatic drain_all();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(REG_FRAME_GAP, c.frame_gap);
        write_reg(REG_SOFT_GAP, c.soft_gap);
        write_reg(REG_HARD_GAP, c.hard_gap);
        write_reg(REG_FREEZE_GAP, c.freeze_gap);
        write_reg(REG_MISS_LIMIT, {8'd0, c.miss_limit});
        write_reg(REG_STEP_LIMIT, {4'd0, c.step_limit});
        write_reg(REG_CHAN_MIN, c.chan_min);
        write_reg(REG_CHAN_MAX, c.chan_max);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_FRAME_GAP;
        i_cfg_data    <= 16'd0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_LINK;
        i_now_ms      <= 32'd0;
        i_bytes_seen  <= 1'b0;
        i_throttle_in <= 16'd0;
        i_steer_in    <= 16'd0;
        i_engine_in   <= 16'd0;
        i_ignition_in <= 16'd0;
        i_starter_in  <= 16'd0;
        cur_cfg = {RST_FRAME_GAP, RST_SOFT_GAP, RST_HARD_GAP, RST_FREEZE_GAP,
                   RST_MISS_LIMIT, RST_STEP_LIMIT, RST_CHAN_MIN, RST_CHAN_MAX};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings.
        // Before any frame: a channel request is still judged by frame age.
        send_req(make_req(KIND_LINK, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(KIND_CHAN, 32'd100, 1'b0, 16'd1500, 16'd1500, 16'd1500,
                          16'd1500, 16'd1500));
        // Byte gaps pile up into soft loss; the last one is also a hard loss.
        send_req(make_req(KIND_LINK, 32'd200, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(KIND_LINK, 32'd330, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_req(make_req(KIND_LINK, 32'd600, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        // Channel request during soft loss does nothing.
        send_req(make_req(KIND_CHAN, 32'd610, 1'b1, 16'd1500, 16'd1500, 16'd1500,
                          16'd1500, 16'd1500));
        // A good frame recovers the link.
        send_req(make_req(KIND_LINK, 32'd620, 1'b1, 16'd1500, 16'd1500, 16'hFFFF,
                          16'hFFFF, 16'hFFFF));
        // Slew limiting in both directions, then the range checks.
        send_req(make_req(KIND_CHAN, 32'd630, 1'b0, 16'd2100, 16'd900, 16'd1000,
                          16'd1100, 16'd1200));
        send_req(make_req(KIND_CHAN, 32'd640, 1'b0, 16'hFFFF, 16'd1500, 16'd1500,
                          16'd1500, 16'd1500));
        send_req(make_req(KIND_CHAN, 32'd650, 1'b0, 16'd1500, 16'd1500, 16'd899,
                          16'd1500, 16'd1500));
        send_req(make_req(KIND_CHAN, 32'd660, 1'b0, 16'd1500, 16'd1500, 16'd1500,
                          16'd1500, 16'd2101));
        send_req(make_req(KIND_CHAN, 32'd670, 1'b0, 16'd900, 16'd900, 16'd900,
                          16'd900, 16'd900));
        send_req(make_req(KIND_CHAN, 32'd680, 1'b0, 16'd2100, 16'd2100, 16'd2100,
                          16'd2100, 16'd2100));
        // Bytes without a valid frame: frame misses run into the timeout.
        send_req(make_req(KIND_LINK, 32'd700, 1'b1, 16'd899, 16'd1500, 16'd0,
                          16'd0, 16'd0));
        send_req(make_req(KIND_LINK, 32'd770, 1'b1, 16'd2101, 16'd1500, 16'd0,
                          16'd0, 16'd0));
        send_req(make_req(KIND_LINK, 32'd840, 1'b1, 16'd1500, 16'd0, 16'd0,
                          16'd0, 16'd0));
        // Frozen channels.
        send_req(make_req(KIND_CHAN, 32'd1000, 1'b0, 16'd1500, 16'd1500, 16'd1500,
                          16'd1500, 16'd1500));
        // Time wraps around the top of the counter.
        send_req(make_req(KIND_LINK, 32'hFFFF_FFF0, 1'b1, 16'd1500, 16'd1600, 16'd0,
                          16'd0, 16'd0));
        send_req(make_req(KIND_LINK, 32'h0000_0010, 1'b1, 16'd1400, 16'd1500, 16'd0,
                          16'd0, 16'd0));
        send_req(make_req(KIND_CHAN, 32'h0000_0020, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF));
        send_req(make_req(KIND_CHAN, 32'h0000_0030, 1'b0, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'd0));
        send_req(make_req(KIND_CHAN, 32'h0000_0040, 1'b0, 16'd2000, 16'd1000, 16'd2100,
                          16'd900, 16'd1500));
        clock_ms = 32'h0000_0040;

        // Random phases, each under its own register settings.
        for (int phase = 1; phase <= 9; phase++) begin
            drain_all();
            cur_cfg = phase_cfg(phase);
            program_regs(cur_cfg);
            calm = (phase % 4 == 2);
            repeat (100) send_req(rand_req());
        end
        drain_all();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
